@@ src/rfp_pkg.sv @@
// ----------------------------------------------------------------------------
// rfp_pkg
// Shared types, sizes and command codes for the ring FIFO with peek.
// ----------------------------------------------------------------------------
`default_nettype none

package rfp_pkg;

  // Number of slots in the ring; one slot always stays empty.
  localparam int SLOTS      = 16;
  // Bytes kept of each element (at most four reach the store).
  localparam int ELEM_BYTES = 4;

  localparam int ELEM_BITS  = 8 * ((ELEM_BYTES < 4) ? ELEM_BYTES : 4);
  localparam int PTR_W      = (SLOTS > 2) ? $clog2(SLOTS) : 1;
  localparam int CNT_W      = PTR_W + 1;
  localparam int IDX_W      = ((CNT_W > 4) ? CNT_W : 4) + 1;

  localparam int CMD_W      = 3;
  localparam int DATA_W     = 32;
  localparam int IN_W       = 40;
  localparam int OUT_W      = 40;

  typedef logic [PTR_W-1:0]     ptr_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [ELEM_BITS-1:0] elem_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 3'd0,
    CMD_POP   = 3'd1,
    CMD_PEEK  = 3'd2,
    CMD_FLUSH = 3'd3,
    CMD_QUERY = 3'd4
  } cmd_t;

  // Advance a slot index by one, wrapping at the end of the ring.
  function automatic ptr_t next_slot(input ptr_t s);
    ptr_t r;
    if (s == ptr_t'(SLOTS - 1)) begin
      r = '0;
    end else begin
      r = s + ptr_t'(1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/ring_fifo_with_peek.sv @@
// ----------------------------------------------------------------------------
// ring_fifo_with_peek
// Ring-buffer FIFO with push, pop, peek at an offset, flush and empty query.
// ----------------------------------------------------------------------------
// Usage:
// Commands arrive as beats on the s_ channel; each command yields exactly one
// result beat on the m_ channel carrying a success flag, the data read by a
// pop or peek (zero otherwise) and the empty flag after the command.
// The ring has SLOTS slots and holds at most SLOTS-1 entries. A push to a
// full ring fails unless overwrite is set, in which case the oldest entry is
// dropped first. A peek fails when its offset is not below the entry count.
// The result of a command is offered in the cycle after it is accepted. One
// command is taken per cycle unless a pending result stalls; the pointer update,
// store write and registered store read all occur at the accepting edge.
// The result register is the only buffer: while the receiver stalls with a
// result pending, s_tready stays low; it follows m_tready, so a new command
// is taken at the same edge as the pending result.
// Reset sets head and tail to slot zero (empty ring) and drops any pending
// result; the element store itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module ring_fifo_with_peek (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  // Fields from bit 0: cmd[2:0], push_data[34:3], overwrite[35],
  // peek_index[39:36].
  input  wire logic [rfp_pkg::IN_W-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  // Fields from bit 0: ok[0], read_data[32:1], is_empty[33], zero fill.
  output logic [rfp_pkg::OUT_W-1:0]      m_tdata
);

  // Unpacked command fields.
  logic [rfp_pkg::CMD_W-1:0]  cmd;
  logic [rfp_pkg::DATA_W-1:0] push_data;
  logic                       overwrite;
  logic [3:0]                 peek_index;

  // Ring state.
  rfp_pkg::elem_t store [rfp_pkg::SLOTS];
  rfp_pkg::ptr_t  head;
  rfp_pkg::ptr_t  tail;
  rfp_pkg::ptr_t  head_next;
  rfp_pkg::ptr_t  tail_next;

  // Command decode.
  logic           accept;
  logic           full;
  logic           empty;
  rfp_pkg::ptr_t  tail_adv;
  rfp_pkg::cnt_t  count;
  rfp_pkg::idx_t  peek_sum;
  rfp_pkg::ptr_t  rd_addr;
  logic           wr_en;
  logic           rd_hit;
  logic           ok_next;

  // Result register.
  logic           ok;
  logic           is_empty;
  logic           rd_sel;
  rfp_pkg::elem_t rd_data;
  logic [rfp_pkg::DATA_W-1:0] read_data;

  assign cmd        = s_tdata[2:0];
  assign push_data  = s_tdata[34:3];
  assign overwrite  = s_tdata[35];
  assign peek_index = s_tdata[39:36];

  // A new command may enter whenever the result register is free or drains.
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // Occupancy and peek address from the current pointers.
  always_comb begin
    tail_adv = rfp_pkg::next_slot(tail);
    full     = (tail_adv == head);
    empty    = (head == tail);
    count    = rfp_pkg::cnt_t'(tail)
             + ((tail < head) ? rfp_pkg::cnt_t'(rfp_pkg::SLOTS) : '0)
             - rfp_pkg::cnt_t'(head);
    peek_sum = rfp_pkg::idx_t'(head) + rfp_pkg::idx_t'(peek_index);
    if (peek_sum >= rfp_pkg::idx_t'(rfp_pkg::SLOTS)) begin
      peek_sum = peek_sum - rfp_pkg::idx_t'(rfp_pkg::SLOTS);
    end
  end

  // Command execution: pointer updates, store write and read selection.
  always_comb begin
    head_next = head;
    tail_next = tail;
    wr_en     = 1'b0;
    rd_hit    = 1'b0;
    ok_next   = 1'b0;
    rd_addr   = head;
    case (cmd)
      rfp_pkg::CMD_PUSH: begin
        if (!full || overwrite) begin
          wr_en     = 1'b1;
          ok_next   = 1'b1;
          tail_next = tail_adv;
          if (full) begin
            head_next = rfp_pkg::next_slot(head);
          end
        end
      end
      rfp_pkg::CMD_POP: begin
        if (!empty) begin
          rd_hit    = 1'b1;
          ok_next   = 1'b1;
          head_next = rfp_pkg::next_slot(head);
        end
      end
      rfp_pkg::CMD_PEEK: begin
        rd_addr = peek_sum[rfp_pkg::PTR_W-1:0];
        if (rfp_pkg::idx_t'(peek_index) < rfp_pkg::idx_t'(count)) begin
          rd_hit  = 1'b1;
          ok_next = 1'b1;
        end
      end
      rfp_pkg::CMD_FLUSH: begin
        head_next = '0;
        tail_next = '0;
        ok_next   = 1'b1;
      end
      rfp_pkg::CMD_QUERY: begin
        ok_next = 1'b1;
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
  end

  // Pointer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
    end else if (accept) begin
      head <= head_next;
      tail <= tail_next;
    end
  end

  // Element store with a registered read port.
  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      store[tail] <= push_data[rfp_pkg::ELEM_BITS-1:0];
    end
    if (accept && rd_hit) begin
      rd_data <= store[rd_addr];
    end
  end

  // Result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      ok       <= ok_next;
      rd_sel   <= rd_hit;
      is_empty <= (head_next == tail_next);
    end
  end

  assign read_data = rd_sel ? rfp_pkg::DATA_W'(rd_data) : '0;
  assign m_tdata   = {6'd0, is_empty, read_data, ok};

  // Checks on the ring logic.
  a_flush_empties: assert property (@(posedge clk) disable iff (rst)
    accept && cmd == rfp_pkg::CMD_FLUSH |=> m_tvalid && ok && is_empty)
    else $error("flush did not leave the ring empty");

  a_pop_empty_fails: assert property (@(posedge clk) disable iff (rst)
    accept && cmd == rfp_pkg::CMD_POP && head == tail |=> !ok && read_data == '0)
    else $error("pop on an empty ring reported success");

  a_reset_pointers: assert property (@(posedge clk)
    rst |=> head == '0 && tail == '0 && !m_tvalid)
    else $error("reset did not clear the pointers");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    head < rfp_pkg::ptr_t'(rfp_pkg::SLOTS - 1) || head == rfp_pkg::ptr_t'(rfp_pkg::SLOTS - 1))
    else $error("head pointer left the ring");

  a_push_full_kept: assert property (@(posedge clk) disable iff (rst)
    accept && cmd == rfp_pkg::CMD_PUSH && full && !overwrite
    |=> !ok && $stable(head) && $stable(tail))
    else $error("refused push changed the ring");

endmodule

`default_nettype wire

@@ tb/rfp_result_checker.sv @@
// ----------------------------------------------------------------------------
// rfp_result_checker
// Watches both channels of the ring FIFO with peek. It keeps its own copy of
// the ring, works out the reply to every accepted command beat and compares
// each accepted result beat, field by field, with the oldest reply still due.
// ----------------------------------------------------------------------------
module rfp_result_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  input  logic                      s_tready,
  // Fields from bit 0: cmd[2:0], push_data[34:3], overwrite[35],
  // peek_index[39:36].
  input  logic [rfp_pkg::IN_W-1:0]  s_tdata,
  input  logic                      m_tvalid,
  input  logic                      m_tready,
  // Fields from bit 0: ok[0], read_data[32:1], is_empty[33], zero fill.
  input  logic [rfp_pkg::OUT_W-1:0] m_tdata,
  output int                        fail_count,
  output int                        pending,
  output int                        checked
);
  timeunit 1ns;
  timeprecision 1ps;

  import rfp_pkg::*;

  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] rdata;
    logic              empty;
  } reply_t;

  // Our own copy of the ring and its two pointers.
  elem_t  ring_mem [SLOTS];
  ptr_t   oldest;
  ptr_t   next_free;
  reply_t replies_due [$];
  int     faults;
  int     compared;

  function automatic ptr_t wrap_inc(input ptr_t p);
    return (int'(p) == SLOTS - 1) ? ptr_t'(0) : ptr_t'(int'(p) + 1);
  endfunction

  // Applies one command to the ring copy and returns the reply it causes.
  function automatic reply_t apply_command(input logic [CMD_W-1:0] op,
                                           input elem_t din,
                                           input logic ovw,
                                           input logic [3:0] offset);
    reply_t r;
    int     fill;
    ptr_t   after_tail;
    r          = '0;
    fill       = (int'(next_free) + SLOTS - int'(oldest)) % SLOTS;
    after_tail = wrap_inc(next_free);
    case (op)
      CMD_PUSH: begin
        // A full ring only takes the element when the oldest may be dropped.
        if (after_tail != oldest || ovw) begin
          if (after_tail == oldest) begin
            oldest = wrap_inc(oldest);
          end
          ring_mem[next_free] = din;
          next_free = after_tail;
          r.ok = 1'b1;
        end
      end
      CMD_POP: begin
        if (fill != 0) begin
          r.rdata = DATA_W'(ring_mem[oldest]);
          oldest  = wrap_inc(oldest);
          r.ok    = 1'b1;
        end
      end
      CMD_PEEK: begin
        if (int'(offset) < fill) begin
          r.rdata = DATA_W'(ring_mem[ptr_t'((int'(oldest) + int'(offset)) % SLOTS)]);
          r.ok    = 1'b1;
        end
      end
      CMD_FLUSH: begin
        oldest    = '0;
        next_free = '0;
        r.ok      = 1'b1;
      end
      CMD_QUERY: begin
        r.ok = 1'b1;
      end
      default: begin
        // Unused codes leave everything alone and report failure.
      end
    endcase
    r.empty = (oldest == next_free);
    return r;
  endfunction

  task automatic report(input string field, input logic [63:0] want, input logic [63:0] got);
    $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
    faults++;
  endtask

  // Result beats are checked before the command beat of the same edge is
  // predicted, so the reply queue always stays in order.
  always @(posedge clk) begin : watch
    reply_t want;
    reply_t got;
    if (rst) begin
      replies_due.delete();
      oldest    = '0;
      next_free = '0;
      faults    = 0;
      compared  = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.ok    = m_tdata[0];
        got.rdata = m_tdata[32:1];
        got.empty = m_tdata[33];
        if (replies_due.size() == 0) begin
          $display("%0t: result beat with no command waiting, got 0x%0h", $time, m_tdata);
          faults++;
        end else begin
          want = replies_due.pop_front();
          compared++;
          if (got.ok !== want.ok) report("ok", want.ok, got.ok);
          if (got.rdata !== want.rdata) report("read_data", want.rdata, got.rdata);
          if (got.empty !== want.empty) report("is_empty", want.empty, got.empty);
          if (m_tdata[OUT_W-1:34] !== '0) report("fill bits", 0, m_tdata[OUT_W-1:34]);
        end
      end
      if (s_tvalid && s_tready) begin
        replies_due.push_back(apply_command(s_tdata[2:0], elem_t'(s_tdata[3 +: DATA_W]),
                                            s_tdata[35], s_tdata[39:36]));
      end
    end
    pending    <= replies_due.size();
    fail_count <= faults;
    checked    <= compared;
  end

endmodule

@@ tb/tb_ring_fifo_with_peek.sv @@
// ----------------------------------------------------------------------------
// tb_ring_fifo_with_peek
// Drives command beats into the ring FIFO with peek and takes its result
// beats with random gaps and stalls on both sides. A directed opening covers
// the empty and full ring, overwrite, peek limits, flush and unused codes;
// random phases then fill, drain and probe the ring. Checking is done by
// rfp_result_checker, which reports its failure count back here.
// ----------------------------------------------------------------------------
module tb_ring_fifo_with_peek;
  timeunit 1ns;
  timeprecision 1ps;

  import rfp_pkg::*;

  localparam int MAX_GAP      = 18;
  localparam int RANDOM_ITEMS = 850;
  localparam int DRAIN_LIMIT  = 2000;

  // Command codes the block does not use.
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  logic             clk      = 1'b0;
  logic             rst      = 1'b1;
  logic             s_tvalid = 1'b0;
  logic [IN_W-1:0]  s_tdata  = '0;
  logic             m_tready = 1'b0;
  logic             s_tready;
  logic             m_tvalid;
  logic [OUT_W-1:0] m_tdata;

  int fail_count;
  int pending;
  int checked;
  int issued [8];
  bit tx_steady;
  bit rx_steady;
  bit leftover;

  ring_fifo_with_peek i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  rfp_result_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Offers one command beat, after a random gap unless tx_steady is set, and waits until it is taken.
  task automatic send_command(input logic [CMD_W-1:0] op, input logic [DATA_W-1:0] din,
                              input logic ovw, input logic [3:0] offset);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {offset, ovw, din, op};
    do @(posedge clk); while (!s_tready);
    issued[op]++;
  endtask

  // Holds the sender back until every reply due has arrived, or the limit.
  task automatic settle(input int limit);
    @(negedge clk);
    s_tvalid <= 1'b0;
    for (int n = 0; n < limit && pending != 0; n++) @(posedge clk);
  endtask

  // Result sink: a random stall before each beat it takes, unless rx_steady is set.
  initial begin : sink
    int stall;
    wait (!rst);
    forever begin
      stall = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
      @(negedge clk);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  initial begin : stimulus
    logic [CMD_W-1:0] op;
    int               mode;
    int               phase_left;
    int               roll;
    int               push_cut;
    int               pop_cut;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty ring: failing pop and peek, query and the unused codes.
    send_command(CMD_POP, '0, 1'b0, 4'd0);
    send_command(CMD_PEEK, '1, 1'b1, 4'd0);
    send_command(CMD_QUERY, '0, 1'b0, 4'd15);
    send_command(CMD_SPARE_LO, '1, 1'b1, 4'd15);
    send_command(CMD_SPARE_HI, '0, 1'b0, 4'd0);
    // Fill the ring to its capacity of SLOTS-1 entries.
    for (int k = 0; k < SLOTS - 1; k++) begin
      send_command(CMD_PUSH, (k == 0) ? '0 : (k == 1) ? '1 : $urandom(), 1'b0, 4'd0);
    end
    // Full ring: refused push, overwriting push, last valid and first bad peek.
    send_command(CMD_PUSH, '1, 1'b0, 4'd0);
    send_command(CMD_PUSH, 32'h5a5a_a5a5, 1'b1, 4'd0);
    send_command(CMD_PEEK, '0, 1'b0, 4'd14);
    send_command(CMD_PEEK, '0, 1'b0, 4'd15);
    send_command(CMD_POP, '0, 1'b0, 4'd0);
    send_command(CMD_FLUSH, '0, 1'b0, 4'd0);
    send_command(CMD_POP, '0, 1'b0, 4'd0);
    settle(DRAIN_LIMIT);

    // Random phases that lean towards filling, draining or a balanced mix.
    phase_left = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(15, 60);
        mode       = $urandom_range(0, 2);
        tx_steady  = ($urandom_range(0, 3) == 0);
        rx_steady  = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 4) == 0) settle(DRAIN_LIMIT);
      end
      phase_left--;
      case (mode)
        0: begin
          push_cut = 60;
          pop_cut  = 75;
        end
        1: begin
          push_cut = 25;
          pop_cut  = 70;
        end
        default: begin
          push_cut = 40;
          pop_cut  = 65;
        end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < push_cut) op = CMD_PUSH;
      else if (roll < pop_cut) op = CMD_POP;
      else if (roll < 90) op = CMD_PEEK;
      else if (roll < 96) op = CMD_QUERY;
      else if (roll < 97) op = CMD_FLUSH;
      else op = CMD_W'($urandom_range(int'(CMD_SPARE_LO), int'(CMD_SPARE_HI)));
      send_command(op, $urandom(), 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
    end

    settle(DRAIN_LIMIT);
    if (pending != 0) begin
      $display("%0t: %0d result beats never arrived", $time, pending);
      leftover = 1'b1;
    end
    repeat (4) @(posedge clk);
    $display("Sent %0d push, %0d pop, %0d peek, %0d flush, %0d query and %0d unused commands.",
             issued[CMD_PUSH], issued[CMD_POP], issued[CMD_PEEK], issued[CMD_FLUSH],
             issued[CMD_QUERY], issued[5] + issued[6] + issued[7]);
    $display("Checked %0d result beats against the predicted ring contents.", checked);
    if (fail_count == 0 && !leftover) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #1_000_000;
    $display("%0t: run timed out", $time);
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ filelist.f @@
src/rfp_pkg.sv
src/ring_fifo_with_peek.sv
tb/rfp_result_checker.sv
tb/tb_ring_fifo_with_peek.sv
